[rtl/core/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the binary max-heap priority queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN_GET,
        ST_DN,
        ST_DN_R,
        ST_DN_CMP,
        ST_DONE
    } t_state;

    // result status codes
    localparam int unsigned STATUS_W = 2;
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    // request kinds carried on tuser
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

endpackage

`default_nettype wire

[rtl/core/max_heap_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// max_heap_priority_queue_core
// Bounded binary max-heap priority queue; slots live in one synchronous RAM,
// the entry being sifted is held in a register and written once it settles.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                         | tuser
//  s       | in  | in_value, in_priority                         | action
//  m       | out | out_value, out_priority, status, entry_count, | -
//          |     | top_value, queue_empty, zero fill             |
//
//  One request at a time. Insert climbs one level per parent read then
//  compare/write pair. Pop descends one level per two child reads through
//  the single RAM read port and a compare/write.
//  Reset is synchronous; the queue comes up empty, no clearing pass.
//  A held result blocks only the final hand-off; the next request is taken
//  as soon as the result is loaded into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue_core #(
    parameter  int unsigned DEPTH          = 64,
    parameter  int unsigned VALUE_WIDTH    = 32,
    parameter  int unsigned PRIORITY_WIDTH = 16,
    localparam int unsigned CNT_W          = $clog2(DEPTH + 1),
    localparam int unsigned IN_W           = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
    localparam int unsigned OUT_W          =
        ((2 * VALUE_WIDTH + PRIORITY_WIDTH + mhpq_pkg::STATUS_W + CNT_W + 1 + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request stream
    input  wire logic             i_s_tvalid,
    output      logic             o_s_tready,
    input  wire logic [IN_W-1:0]  i_s_tdata,   // in_value, in_priority, zero fill
    input  wire logic             i_s_tuser,   // action
    // result stream
    output      logic             o_m_tvalid,
    input  wire logic             i_m_tready,
    output      logic [OUT_W-1:0] o_m_tdata    // out_value, out_priority, status,
                                               // entry_count, top_value,
                                               // queue_empty, zero fill
);

    import mhpq_pkg::*;

    localparam int unsigned VW     = VALUE_WIDTH;
    localparam int unsigned PW     = PRIORITY_WIDTH;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned DW     = VW + PW;
    localparam int unsigned O_OVAL = 0;
    localparam int unsigned O_OPRI = O_OVAL + VW;
    localparam int unsigned O_STAT = O_OPRI + PW;
    localparam int unsigned O_CNT  = O_STAT + STATUS_W;
    localparam int unsigned O_TOP  = O_CNT + CNT_W;
    localparam int unsigned O_EMP  = O_TOP + VW;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ROOT_SLOT = CNT_W'(1);

    // slot number (1-based) to RAM address
    function automatic logic [AW-1:0] f_addr(input logic [CNT_W-1:0] slot);
        logic [CNT_W-1:0] t;
        t = slot - ROOT_SLOT;
        return t[AW-1:0];
    endfunction

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [VW-1:0]     r_e_val, n_e_val;
    logic [PW-1:0]     r_e_pri, n_e_pri;
    logic [VW-1:0]     r_c_val, n_c_val;
    logic [PW-1:0]     r_c_pri, n_c_pri;
    logic              r_has_r, n_has_r;
    logic [VW-1:0]     r_top_val;
    logic [PW-1:0]     r_top_pri;
    logic [VW-1:0]     r_pop_val, n_pop_val;
    logic [PW-1:0]     r_pop_pri, n_pop_pri;
    t_status           r_status, n_status;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic              w_in_fire;
    logic              w_out_free;
    logic [VW-1:0]     w_in_val;
    logic [PW-1:0]     w_in_pri;
    logic [DW-1:0]     w_rdata;
    logic [VW-1:0]     w_rd_val;
    logic [PW-1:0]     w_rd_pri;
    logic              w_up_gt;
    logic [CNT_W:0]    w_j;
    logic              w_j_past;
    logic              w_right_gt;
    logic [VW-1:0]     w_ch_val;
    logic [PW-1:0]     w_ch_pri;
    logic [CNT_W-1:0]  w_ch_idx;
    logic              w_child_gt;
    logic [OUT_W-1:0]  w_pack;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    // slot memory
    mhpq_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (DW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (w_rdata)
    );

    // handshakes and field unpacking
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_in_fire  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_in_val   = i_s_tdata[VW-1:0];
    assign w_in_pri   = i_s_tdata[VW+PW-1:VW];
    assign w_rd_val   = w_rdata[VW-1:0];
    assign w_rd_pri   = w_rdata[DW-1:VW];

    // sift comparisons
    assign w_up_gt    = $signed(r_e_pri) > $signed(w_rd_pri);
    assign w_j        = {r_i, 1'b0};
    assign w_j_past   = w_j > {1'b0, r_count};
    assign w_right_gt = r_has_r && ($signed(w_rd_pri) > $signed(r_c_pri));
    assign w_ch_val   = w_right_gt ? w_rd_val : r_c_val;
    assign w_ch_pri   = w_right_gt ? w_rd_pri : r_c_pri;
    assign w_ch_idx   = w_right_gt ? (r_j + ROOT_SLOT) : r_j;
    assign w_child_gt = $signed(w_ch_pri) > $signed(r_e_pri);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    if (i_s_tuser == ACT_POP) begin
                        n_state = (r_count == '0) ? ST_DONE : ST_DN_LAST;
                    end else if (r_count == FULL_CNT || r_count == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_UP;
                    end
                end
            end
            ST_UP:      n_state = (r_i == ROOT_SLOT) ? ST_DONE : ST_UP_CMP;
            ST_UP_CMP:  n_state = w_up_gt ? ST_UP : ST_DONE;
            ST_DN_LAST: n_state = ST_DN_GET;
            ST_DN_GET:  n_state = (r_count == '0) ? ST_DONE : ST_DN;
            ST_DN:      n_state = w_j_past ? ST_DONE : ST_DN_R;
            ST_DN_R:    n_state = ST_DN_CMP;
            ST_DN_CMP:  n_state = w_child_gt ? ST_DN : ST_DONE;
            ST_DONE:    n_state = w_out_free ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count   = r_count;
        n_i       = r_i;
        n_j       = r_j;
        n_e_val   = r_e_val;
        n_e_pri   = r_e_pri;
        n_c_val   = r_c_val;
        n_c_pri   = r_c_pri;
        n_has_r   = r_has_r;
        n_pop_val = r_pop_val;
        n_pop_pri = r_pop_pri;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = {r_e_pri, r_e_val};
        mem_re    = 1'b0;
        mem_raddr = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_pop_val = '0;
                    n_pop_pri = '0;
                    n_status  = STAT_OK;
                    if (i_s_tuser == ACT_POP) begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            n_pop_val = r_top_val;
                            n_pop_pri = r_top_pri;
                            n_count   = r_count - ROOT_SLOT;
                        end
                    end else if (r_count == FULL_CNT) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_count = r_count + ROOT_SLOT;
                        n_i     = r_count + ROOT_SLOT;
                        n_e_val = w_in_val;
                        n_e_pri = w_in_pri;
                        // first entry goes straight to the root
                        if (r_count == '0) begin
                            mem_we    = 1'b1;
                            mem_wdata = {w_in_pri, w_in_val};
                        end
                    end
                end
            end
            ST_UP: begin
                if (r_i == ROOT_SLOT) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = f_addr(r_i >> 1);
                end
            end
            ST_UP_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_i);
                if (w_up_gt) begin
                    mem_wdata = w_rdata;
                    n_i       = r_i >> 1;
                end
            end
            ST_DN_LAST: begin
                // old last slot sits at address equal to the new count
                mem_re    = 1'b1;
                mem_raddr = r_count[AW-1:0];
            end
            ST_DN_GET: begin
                n_e_val = w_rd_val;
                n_e_pri = w_rd_pri;
                n_i     = ROOT_SLOT;
            end
            ST_DN: begin
                if (w_j_past) begin
                    mem_we    = 1'b1;
                    mem_waddr = f_addr(r_i);
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = f_addr(w_j[CNT_W-1:0]);
                    n_j       = w_j[CNT_W-1:0];
                end
            end
            ST_DN_R: begin
                n_c_val = w_rd_val;
                n_c_pri = w_rd_pri;
                n_has_r = r_j < r_count;
                if (r_j < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_j[AW-1:0];
                end
            end
            ST_DN_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = f_addr(r_i);
                if (w_child_gt) begin
                    mem_wdata = {w_ch_pri, w_ch_val};
                    n_i       = w_ch_idx;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // result packing
    always_comb begin
        w_pack = '0;
        w_pack[O_OVAL +: VW]       = r_pop_val;
        w_pack[O_OPRI +: PW]       = r_pop_pri;
        w_pack[O_STAT +: STATUS_W] = r_status;
        w_pack[O_CNT +: CNT_W]     = r_count;
        w_pack[O_TOP +: VW]        = (r_count != '0) ? r_top_val : '0;
        w_pack[O_EMP]              = (r_count == '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_e_val   <= n_e_val;
        r_e_pri   <= n_e_pri;
        r_c_val   <= n_c_val;
        r_c_pri   <= n_c_pri;
        r_has_r   <= n_has_r;
        r_pop_val <= n_pop_val;
        r_pop_pri <= n_pop_pri;
        r_status  <= n_status;
        // root copy follows every write to slot one
        if (mem_we && mem_waddr == '0) begin
            r_top_val <= mem_wdata[VW-1:0];
            r_top_pri <= mem_wdata[DW-1:VW];
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_data <= w_pack;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // held count never passes capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above capacity");

    // no read and write of the same slot in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re && mem_waddr == mem_raddr))
        else $error("read and write hit the same slot");

    // accepted insert on a queue with room grows it by one
    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_s_tuser == ACT_INSERT && r_count != FULL_CNT)
        |=> r_count == $past(r_count) + ROOT_SLOT)
        else $error("insert did not grow the queue");

    // a full report carries a full count
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[O_STAT +: STATUS_W] == STAT_FULL)
        |-> r_out_data[O_CNT +: CNT_W] == FULL_CNT)
        else $error("full status with count below capacity");

    // an empty report carries the empty flag
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[O_STAT +: STATUS_W] == STAT_EMPTY)
        |-> r_out_data[O_EMP])
        else $error("empty status without empty flag");
`endif

endmodule

`default_nettype wire

[rtl/core/mhpq_store.sv]
// ----------------------------------------------------------------------------
// mhpq_store
// Heap slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_store #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6,
    parameter int unsigned DATA_W = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] r_rdata;

    // synchronous write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the max-heap priority queue core: a queue of
// insert and pop requests is streamed in, a local heap predicts every
// result, and each result transfer is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mhpq_pkg::*;

    localparam int unsigned DEPTH    = 64;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned PRIO_W   = 16;
    localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
    localparam int unsigned IN_W     = ((VAL_W + PRIO_W + 7) / 8) * 8;
    localparam int unsigned OUT_W    =
        ((2 * VAL_W + PRIO_W + STATUS_W + CNT_W + 1 + 7) / 8) * 8;
    localparam int unsigned N_RANDOM = 900;
    localparam int unsigned MAX_CYC  = 400000;
    localparam int unsigned TAIL_CYC = 50;

    // result field positions in tdata, lowest bit first
    localparam int unsigned POS_OPRIO  = VAL_W;
    localparam int unsigned POS_STATUS = POS_OPRIO + PRIO_W;
    localparam int unsigned POS_COUNT  = POS_STATUS + STATUS_W;
    localparam int unsigned POS_TOP    = POS_COUNT + CNT_W;
    localparam int unsigned POS_EMPTY  = POS_TOP + VAL_W;

    typedef struct {
        logic                     action;
        logic signed [VAL_W-1:0]  value;
        logic signed [PRIO_W-1:0] prio;
    } request_t;

    typedef struct {
        logic signed [VAL_W-1:0]  out_value;
        logic signed [PRIO_W-1:0] out_priority;
        t_status                  status;
        logic [CNT_W-1:0]         entry_count;
        logic signed [VAL_W-1:0]  top_value;
        logic                     queue_empty;
    } heap_result_t;

    typedef enum int {RUN_FILL, RUN_DRAIN, RUN_MIXED} run_kind_t;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [IN_W-1:0]  i_s_tdata  = '0;     // in_value, in_priority
    logic             i_s_tuser  = 1'b0;   // action
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;           // out_value, out_priority, status,
                                           // entry_count, top_value,
                                           // queue_empty, zero fill

    request_t     request_q [$];
    heap_result_t expected_q [$];
    int unsigned  total_requests = 0;
    int unsigned  requests_taken = 0;
    int unsigned  errors         = 0;
    bit           request_moved  = 1'b0;

    // predicted heap contents, slots 1..held_count
    logic signed [VAL_W-1:0]  heap_val  [1:DEPTH];
    logic signed [PRIO_W-1:0] heap_prio [1:DEPTH];
    int unsigned              held_count = 0;

    max_heap_priority_queue_core #(
        .DEPTH          (DEPTH),
        .VALUE_WIDTH    (VAL_W),
        .PRIORITY_WIDTH (PRIO_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // apply one request to the local heap and work out its result
    task automatic heap_apply(input request_t rq, output heap_result_t r);
        int unsigned              i;
        int unsigned              j;
        logic signed [VAL_W-1:0]  tv;
        logic signed [PRIO_W-1:0] tp;
        bit                       settled;
        r.out_value    = '0;
        r.out_priority = '0;
        r.status       = STAT_OK;
        if (rq.action == ACT_INSERT) begin
            if (held_count >= DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                held_count++;
                i = held_count;
                heap_val[i]  = rq.value;
                heap_prio[i] = rq.prio;
                // climb while strictly above the parent
                while (i > 1 && heap_prio[i] > heap_prio[i / 2]) begin
                    tv = heap_val[i];  heap_val[i]  = heap_val[i / 2];  heap_val[i / 2]  = tv;
                    tp = heap_prio[i]; heap_prio[i] = heap_prio[i / 2]; heap_prio[i / 2] = tp;
                    i = i / 2;
                end
            end
        end else if (held_count == 0) begin
            r.status = STAT_EMPTY;
        end else begin
            r.out_value    = heap_val[1];
            r.out_priority = heap_prio[1];
            heap_val[1]    = heap_val[held_count];
            heap_prio[1]   = heap_prio[held_count];
            held_count--;
            i       = 1;
            settled = 1'b0;
            // sink towards the larger child, left child on a tie
            while (!settled && 2 * i <= held_count) begin
                j = 2 * i;
                if (j < held_count && heap_prio[j + 1] > heap_prio[j])
                    j++;
                if (heap_prio[i] >= heap_prio[j]) begin
                    settled = 1'b1;
                end else begin
                    tv = heap_val[i];  heap_val[i]  = heap_val[j];  heap_val[j]  = tv;
                    tp = heap_prio[i]; heap_prio[i] = heap_prio[j]; heap_prio[j] = tp;
                    i = j;
                end
            end
        end
        r.entry_count = CNT_W'(held_count);
        r.top_value   = (held_count != 0) ? heap_val[1] : '0;
        r.queue_empty = (held_count == 0);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic add_request(input logic act, input logic [VAL_W-1:0] v,
                               input logic [PRIO_W-1:0] p);
        request_t rq;
        rq.action = act;
        rq.value  = v;
        rq.prio   = p;
        request_q.push_back(rq);
    endtask

    // random priority: narrow band for ties, extremes, or anything
    function automatic logic [PRIO_W-1:0] pick_prio();
        logic [PRIO_W-1:0] p;
        case ($urandom_range(3))
            0: p = PRIO_W'($urandom_range(4)) - PRIO_W'(2);
            1: begin
                case ($urandom_range(3))
                    0: p = {1'b1, {(PRIO_W-1){1'b0}}};
                    1: p = {1'b0, {(PRIO_W-1){1'b1}}};
                    2: p = '1;
                    default: p = '0;
                endcase
            end
            default: p = PRIO_W'($urandom);
        endcase
        return p;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(9))
            0: v = {1'b1, {(VAL_W-1){1'b0}}};
            1: v = {1'b0, {(VAL_W-1){1'b1}}};
            default: v = VAL_W'($urandom);
        endcase
        return v;
    endfunction

    // request list: directed opening, then runs of fills, drains and mixes
    initial begin
        int unsigned fill;
        int unsigned extra;
        int unsigned len;
        run_kind_t   kind;
        bit          first_run;
        add_request(ACT_POP, '0, '0);
        add_request(ACT_INSERT, 32'sd0, 16'sd0);
        add_request(ACT_INSERT, 32'h7fff_ffff, 16'h7fff);
        add_request(ACT_INSERT, 32'h8000_0000, 16'h8000);
        add_request(ACT_INSERT, 32'hffff_ffff, 16'hffff);
        add_request(ACT_INSERT, 32'sd5, 16'h7fff);
        add_request(ACT_INSERT, 32'h5555_aaaa, 16'sd1);
        add_request(ACT_INSERT, 32'haaaa_5555, 16'h8000);
        repeat (8) add_request(ACT_POP, '0, '0);
        add_request(ACT_INSERT, 32'sd123, 16'h8000);
        add_request(ACT_INSERT, 32'sd456, 16'h8000);
        add_request(ACT_INSERT, 32'sd789, 16'sd7);
        add_request(ACT_POP, 32'hffff_ffff, 16'hffff);
        repeat (3) add_request(ACT_POP, '0, '0);
        fill      = 0;
        first_run = 1'b1;
        while (request_q.size() < 23 + N_RANDOM) begin
            kind      = first_run ? RUN_FILL : run_kind_t'($urandom_range(2));
            first_run = 1'b0;
            case (kind)
                RUN_FILL: begin
                    while (fill < DEPTH) begin
                        add_request(ACT_INSERT, pick_value(), pick_prio());
                        fill++;
                    end
                    extra = $urandom_range(1, 4);
                    repeat (extra) add_request(ACT_INSERT, pick_value(), pick_prio());
                end
                RUN_DRAIN: begin
                    while (fill > 0) begin
                        add_request(ACT_POP, pick_value(), pick_prio());
                        fill--;
                    end
                    extra = $urandom_range(1, 3);
                    repeat (extra) add_request(ACT_POP, pick_value(), pick_prio());
                end
                default: begin
                    len = $urandom_range(20, 60);
                    repeat (len) begin
                        if ($urandom_range(99) < 55) begin
                            add_request(ACT_INSERT, pick_value(), pick_prio());
                            if (fill < DEPTH) fill++;
                        end else begin
                            add_request(ACT_POP, pick_value(), pick_prio());
                            if (fill > 0) fill--;
                        end
                    end
                end
            endcase
        end
        total_requests = request_q.size();
    end

    // reset
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // request driver and result back-pressure, updated on the falling edge
    always @(negedge i_clk) begin
        int unsigned send_idle;
        int unsigned recv_idle;
        int unsigned phase;
        bit          moved;
        phase = (total_requests == 0) ? 0 : (requests_taken * 3) / total_requests;
        case (phase)
            0:       begin send_idle = 9;  recv_idle = 84; end
            1:       begin send_idle = 84; recv_idle = 9;  end
            default: begin send_idle = 0;  recv_idle = 0;  end
        endcase
        moved = request_moved;
        if (moved) begin
            void'(request_q.pop_front());
            request_moved = 1'b0;
        end
        if (i_rst_n) begin
            if (!i_s_tvalid || moved) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= IN_W'({request_q[0].prio, request_q[0].value});
                    i_s_tuser  <= request_q[0].action;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // request and result transfers seen on the rising edge
    always @(posedge i_clk) begin
        request_t     rq;
        heap_result_t want;
        heap_result_t got;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                rq.action = i_s_tuser;
                rq.value  = i_s_tdata[VAL_W-1:0];
                rq.prio   = i_s_tdata[VAL_W +: PRIO_W];
                heap_apply(rq, want);
                expected_q.push_back(want);
                requests_taken++;
                request_moved = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.out_value    = o_m_tdata[VAL_W-1:0];
                got.out_priority = o_m_tdata[POS_OPRIO +: PRIO_W];
                got.status       = o_m_tdata[POS_STATUS +: STATUS_W];
                got.entry_count  = o_m_tdata[POS_COUNT +: CNT_W];
                got.top_value    = o_m_tdata[POS_TOP +: VAL_W];
                got.queue_empty  = o_m_tdata[POS_EMPTY];
                if (expected_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_value", want.out_value, got.out_value);
                    check_field("out_priority", want.out_priority, got.out_priority);
                    check_field("status", want.status, got.status);
                    check_field("entry_count", want.entry_count, got.entry_count);
                    check_field("top_value", want.top_value, got.top_value);
                    check_field("queue_empty", want.queue_empty, got.queue_empty);
                end
            end
        end
    end

    // end of run once every request is in and every result is out
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (total_requests != 0 && requests_taken == total_requests
                    && expected_q.size() == 0)
                break;
        end
        repeat (TAIL_CYC) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        int unsigned cycles;
        for (cycles = 0; cycles < MAX_CYC; cycles++)
            @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
